// ===== hw/rtl/ffba_pkg.sv =====
// Shared types and codes for the first-fit block allocator.
// No dependencies.
package ffba_pkg;

  localparam int unsigned OffW   = 22;
  localparam int unsigned BytesW = 23;
  localparam int unsigned StatW  = 3;

  typedef enum logic [2:0] {
    StDone     = 3'd0,
    StZeroSize = 3'd1,
    StNoFit    = 3'd2,
    StBadFree  = 3'd3,
    StNullFree = 3'd4
  } status_e;

  // Classified request handed from front to back
  typedef struct packed {
    logic              is_free;
    logic              trivial;   // answered without touching the table
    status_e           status;
    logic [BytesW-1:0] need;      // rounded size for allocate
    logic [OffW-1:0]   foff;
  } req_t;

endpackage

// ===== hw/rtl/ffba_front.sv =====
// Front end: accepts requests, rounds sizes and flags trivial cases.
// Depends on ffba_pkg.
module ffba_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  output logic                       full_o,
  input  logic                       mode_i,
  input  logic [ffba_pkg::BytesW-1:0] request_bytes_i,
  input  logic [ffba_pkg::OffW-1:0]   free_offset_i,
  output logic                       req_valid_o,
  output ffba_pkg::req_t             req_o,
  input  logic                       req_take_i
);
  import ffba_pkg::*;

  // Two-entry queue between front and back
  req_t        q_mem [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  req_t        cls;
  logic [BytesW:0] rnd;
  logic        do_push, do_pop;

  // Classify the incoming transaction
  always_comb begin
    rnd = ({1'b0, request_bytes_i} + (BytesW+1)'(15)) & ~(BytesW+1)'(15);
    cls.is_free = mode_i;
    cls.need    = rnd[BytesW-1:0];
    cls.foff    = free_offset_i;
    cls.trivial = 1'b0;
    cls.status  = StDone;
    if (!mode_i && request_bytes_i == '0) begin
      cls.trivial = 1'b1;
      cls.status  = StZeroSize;
    end else if (mode_i && free_offset_i == '0) begin
      cls.trivial = 1'b1;
      cls.status  = StNullFree;
    end else if (!mode_i && rnd[BytesW]) begin
      cls.trivial = 1'b1;   // larger than any arena
      cls.status  = StNoFit;
    end
  end

  assign full_o      = cnt_q == 2'd2;
  assign req_valid_o = cnt_q != 2'd0;
  assign req_o       = q_mem[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = req_take_i && req_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) q_mem[wr_ptr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== hw/rtl/ffba_back.sv =====
// Back end: walks the block table for search, split shift and coalescing.
// Depends on ffba_pkg.
module ffba_back #(
  parameter int unsigned ArenaBytes    = 4194304,
  parameter int unsigned HeaderBytes   = 24,
  parameter int unsigned MinSplitBytes = 16,
  parameter int unsigned MaxBlocks     = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  ffba_pkg::req_t              req_i,
  output logic                        req_take_o,
  output logic                        res_valid_o,
  input  logic                        res_take_i,
  output logic [ffba_pkg::OffW-1:0]   payload_offset_o,
  output logic [ffba_pkg::StatW-1:0]  status_o,
  output logic [ffba_pkg::BytesW-1:0] bytes_used_o,
  output logic [ffba_pkg::BytesW-1:0] bytes_free_o
);
  import ffba_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxBlocks);
  localparam int unsigned CntW = $clog2(MaxBlocks + 1);
  localparam int unsigned SzW  = BytesW + 1;

  typedef enum logic [10:0] {
    SIdle   = 11'b00000000001,
    SRead   = 11'b00000000010,
    SCheck  = 11'b00000000100,
    SShRd   = 11'b00000001000,
    SShWr   = 11'b00000010000,
    SFin    = 11'b00000100000,
    SMrgRd  = 11'b00001000000,
    SMrgChk = 11'b00010000000,
    SDnRd   = 11'b00100000000,
    SDnWr   = 11'b01000000000,
    SResult = 11'b10000000000
  } state_e;

  // Table memory: start, size, free in one word
  localparam int unsigned EntW = OffW + SzW + 1;
  logic [EntW-1:0] mem [MaxBlocks];
  logic [EntW-1:0] rd_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_wa, mem_ra;
  logic [EntW-1:0] mem_wd;

  state_e          st_q, st_d;
  logic [CntW-1:0] count_q, count_d;
  logic [BytesW-1:0] used_q, used_d;
  logic [CntW-1:0] i_q, i_d;          // walk index
  logic [CntW-1:0] hit_q, hit_d;
  logic [OffW-1:0] hstart_q, hstart_d;
  logic [SzW-1:0]  hsize_q, hsize_d;
  logic            split_q, split_d;
  logic            merging_q, merging_d; // second split write / left-neighbor phase
  logic [OffW-1:0] pay_q, pay_d;
  status_e         stat_q, stat_d;
  logic            clr_q, clr_d;      // reset clearing pass
  req_t            req_q;             // request being worked

  logic [OffW-1:0] e_start;
  logic [SzW-1:0]  e_size;
  logic            e_free;

  assign e_start = rd_q[EntW-1 -: OffW];
  assign e_size  = rd_q[1 +: SzW];
  assign e_free  = rd_q[0];

  function automatic logic [EntW-1:0] ent(logic [OffW-1:0] s, logic [SzW-1:0] z, logic f);
    return {s, z, f};
  endfunction

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  // Main sequencer
  always_comb begin
    st_d = st_q; count_d = count_q; used_d = used_q; i_d = i_q; hit_d = hit_q;
    hstart_d = hstart_q; hsize_d = hsize_q; split_d = split_q;
    merging_d = merging_q; pay_d = pay_q; stat_d = stat_q; clr_d = clr_q;
    mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_ra = i_q[IdxW-1:0];
    req_take_o = 1'b0;
    unique case (st_q)
      SIdle: begin
        if (clr_q) begin
          mem_we = 1'b1;
          mem_wa = '0;
          mem_wd = ent('0, SzW'(ArenaBytes - HeaderBytes), 1'b1);
          clr_d  = 1'b0;
        end else if (req_valid_i) begin
          req_take_o = 1'b1;
          pay_d  = '0;
          i_d    = '0;
          merging_d = 1'b0;
          if (req_i.trivial) begin
            stat_d = req_i.status;
            st_d   = SResult;
          end else begin
            st_d = SRead;
          end
        end
      end
      SRead: begin
        mem_ra = i_q[IdxW-1:0];
        st_d   = SCheck;
      end
      SCheck: begin
        // read data for entry i_q is now registered
        if (!req_q.is_free && e_free && e_size >= {1'b0, req_q.need}) begin
          hit_d    = i_q;
          hstart_d = e_start;
          hsize_d  = e_size;
          split_d  = (e_size >= SzW'(req_q.need) + SzW'(HeaderBytes) + SzW'(MinSplitBytes))
                     && (count_q < CntW'(MaxBlocks));
          pay_d    = OffW'(e_start + OffW'(HeaderBytes));
          stat_d   = StDone;
          i_d      = count_q;
          st_d     = SFin;
          if ((e_size >= SzW'(req_q.need) + SzW'(HeaderBytes) + SzW'(MinSplitBytes))
              && (count_q < CntW'(MaxBlocks)) && (count_q > i_q + CntW'(1))) begin
            i_d  = count_q - CntW'(1);
            st_d = SShRd;
          end
        end else if (req_q.is_free && !e_free
                     && (OffW+1)'(e_start) + (OffW+1)'(HeaderBytes) == {1'b0, req_q.foff}) begin
          mem_we = 1'b1;
          mem_wa = i_q[IdxW-1:0];
          mem_wd = ent(e_start, e_size, 1'b1);
          used_d = (used_q >= BytesW'(e_size + SzW'(HeaderBytes)))
                   ? used_q - BytesW'(e_size + SzW'(HeaderBytes)) : '0;
          stat_d    = StDone;
          hit_d     = i_q;
          hstart_d  = e_start;
          hsize_d   = e_size;
          merging_d = 1'b0;
          i_d       = i_q + CntW'(1);
          st_d      = SMrgRd;
        end else if (i_q + CntW'(1) >= count_q) begin
          stat_d = req_q.is_free ? StBadFree : StNoFit;
          st_d   = SResult;
        end else begin
          i_d  = i_q + CntW'(1);
          st_d = SRead;
        end
      end
      // shift entries above hit up by one, from the top down
      SShRd: begin
        mem_ra = i_q[IdxW-1:0];
        st_d   = SShWr;
      end
      SShWr: begin
        mem_we = 1'b1;
        mem_wa = IdxW'(i_q + CntW'(1));
        mem_wd = rd_q;
        if (i_q == hit_q + CntW'(1)) st_d = SFin;
        else begin
          i_d  = i_q - CntW'(1);
          st_d = SShRd;
        end
      end
      // finish split or whole grant (a split writes two entries, a whole grant one)
      SFin: begin
        mem_we = 1'b1;
        if (split_q && !merging_q) begin
          mem_wa = IdxW'(hit_q + CntW'(1));
          mem_wd = ent(OffW'(hstart_q + OffW'(HeaderBytes) + OffW'(req_q.need)),
                       hsize_q - SzW'(req_q.need) - SzW'(HeaderBytes), 1'b1);
          merging_d = 1'b1;   // reuse flag: second write pending
        end else begin
          mem_wa = hit_q[IdxW-1:0];
          if (split_q) begin
            mem_wd  = ent(hstart_q, SzW'(req_q.need), 1'b0);
            count_d = count_q + CntW'(1);
            used_d  = used_q + BytesW'(req_q.need) + BytesW'(HeaderBytes);
          end else begin
            mem_wd  = ent(hstart_q, hsize_q, 1'b0);
            used_d  = used_q + BytesW'(hsize_q + SzW'(HeaderBytes));
          end
          merging_d = 1'b0;
          st_d = SResult;
        end
      end
      // coalesce: check right neighbor (merging_q low), then left neighbor
      SMrgRd: begin
        if (!merging_q && i_q >= count_q) begin
          merging_d = 1'b1;
          i_d       = hit_q - CntW'(1);
        end else if (merging_q && hit_q == '0) begin
          st_d = SResult;
        end else begin
          mem_ra = i_q[IdxW-1:0];
          st_d   = SMrgChk;
        end
      end
      SMrgChk: begin
        if (!merging_q) begin
          // rd_q is the right neighbor of the freed block
          if (e_free) begin
            mem_we  = 1'b1;
            mem_wa  = hit_q[IdxW-1:0];
            mem_wd  = ent(hstart_q, hsize_q + e_size + SzW'(HeaderBytes), 1'b1);
            hsize_d = hsize_q + e_size + SzW'(HeaderBytes);
            count_d = count_q - CntW'(1);
            if (i_q + CntW'(1) < count_q) begin
              i_d  = i_q + CntW'(1);
              st_d = SDnRd;
            end else begin
              merging_d = 1'b1;
              i_d       = hit_q - CntW'(1);
              st_d      = SMrgRd;
            end
          end else begin
            merging_d = 1'b1;
            i_d       = hit_q - CntW'(1);
            st_d      = SMrgRd;
          end
        end else begin
          // rd_q is the left neighbor of the freed block
          if (e_free) begin
            mem_we  = 1'b1;
            mem_wa  = i_q[IdxW-1:0];
            mem_wd  = ent(e_start, e_size + hsize_q + SzW'(HeaderBytes), 1'b1);
            count_d = count_q - CntW'(1);
            if (hit_q + CntW'(1) < count_q) begin
              i_d  = hit_q + CntW'(1);
              st_d = SDnRd;
            end else begin
              st_d = SResult;
            end
          end else begin
            st_d = SResult;
          end
        end
      end
      // close the gap: move entries down by one, up to the last entry
      SDnRd: begin
        mem_ra = i_q[IdxW-1:0];
        st_d   = SDnWr;
      end
      SDnWr: begin
        mem_we = 1'b1;
        mem_wa = IdxW'(i_q - CntW'(1));
        mem_wd = rd_q;
        if (i_q >= count_q) begin
          if (!merging_q) begin
            merging_d = 1'b1;
            i_d       = hit_q - CntW'(1);
            st_d      = SMrgRd;
          end else begin
            st_d = SResult;
          end
        end else begin
          i_d  = i_q + CntW'(1);
          st_d = SDnRd;
        end
      end
      SResult: begin
        if (res_take_i) st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; count_q <= CntW'(1); used_q <= '0; i_q <= '0; hit_q <= '0;
      split_q <= 1'b0; merging_q <= 1'b0; stat_q <= StDone; clr_q <= 1'b1;
    end else begin
      st_q <= st_d; count_q <= count_d; used_q <= used_d; i_q <= i_d; hit_q <= hit_d;
      split_q <= split_d; merging_q <= merging_d; stat_q <= stat_d; clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hstart_q <= hstart_d; hsize_q <= hsize_d; pay_q <= pay_d;
    if (req_take_o) req_q <= req_i;
  end

  assign res_valid_o      = st_q == SResult;
  assign payload_offset_o = pay_q;
  assign status_o         = stat_q;
  assign bytes_used_o     = used_q;
  assign bytes_free_o     = BytesW'(ArenaBytes) - used_q;

endmodule

// ===== hw/rtl/first_fit_block_allocator.sv =====
// First-fit block allocator with coalescing over a fixed arena.
// Queue-style request and result channels. Each transaction returns one
// result with offset, status and used/free byte counts.
// Zero-size, null-free and oversize requests go straight to the result
// without touching the table. Otherwise the back end reads and checks
// table entries in turn for the first-fit or offset search. An allocate
// then shifts entries up when a split grows the table and writes the
// granted entry and, on a split, the free remainder. A free checks the
// right and then the left neighbor and moves entries down on each merge.
// One request is worked at a time; a two-entry queue lets the front end
// take up to two more while the back end is busy.
// Reset: the table memory is one free block; entry zero is rewritten by a
// clearing pass after reset, before any request is taken.
// A stalled result (pop low) holds the back end; the front queue keeps
// accepting until it is full.
// Depends on ffba_pkg, ffba_front, ffba_back.
module first_fit_block_allocator #(
  parameter int unsigned ArenaBytes    = 4194304,
  parameter int unsigned HeaderBytes   = 24,
  parameter int unsigned MinSplitBytes = 16,
  parameter int unsigned MaxBlocks     = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        mode_i,
  input  logic [ffba_pkg::BytesW-1:0] request_bytes_i,
  input  logic [ffba_pkg::OffW-1:0]   free_offset_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [ffba_pkg::OffW-1:0]   payload_offset_o,
  output logic [ffba_pkg::StatW-1:0]  status_o,
  output logic [ffba_pkg::BytesW-1:0] bytes_used_o,
  output logic [ffba_pkg::BytesW-1:0] bytes_free_o
);
  import ffba_pkg::*;

  logic req_valid, req_take, res_valid;
  req_t req;

  ffba_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .mode_i, .request_bytes_i,
    .free_offset_i, .req_valid_o(req_valid), .req_o(req), .req_take_i(req_take)
  );

  ffba_back #(
    .ArenaBytes(ArenaBytes), .HeaderBytes(HeaderBytes),
    .MinSplitBytes(MinSplitBytes), .MaxBlocks(MaxBlocks)
  ) u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_i(req), .req_take_o(req_take),
    .res_valid_o(res_valid), .res_take_i(pop), .payload_offset_o, .status_o,
    .bytes_used_o, .bytes_free_o
  );

  assign empty = !res_valid;

endmodule

// ===== hw/rtl/ffba_checker.sv =====
// Port-level checks for the first-fit block allocator.
// Depends on ffba_pkg; bound to first_fit_block_allocator.
module ffba_checker #(
  parameter int unsigned ArenaBytes = 4194304
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        empty,
  input logic                        pop,
  input logic [ffba_pkg::OffW-1:0]   payload_offset_o,
  input logic [ffba_pkg::StatW-1:0]  status_o,
  input logic [ffba_pkg::BytesW-1:0] bytes_used_o,
  input logic [ffba_pkg::BytesW-1:0] bytes_free_o
);
  import ffba_pkg::*;

  // used plus free covers the arena whenever a result is shown
  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (24'(bytes_used_o) + 24'(bytes_free_o) == 24'(ArenaBytes)))
    else $error("used/free mismatch");

  // only a successful allocate grants an offset
  a_pay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && payload_offset_o != '0) |-> status_o == StDone)
    else $error("offset without grant");

  // a waiting result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(payload_offset_o)))
    else $error("result changed while stalled");

endmodule

bind first_fit_block_allocator ffba_checker #(.ArenaBytes(ArenaBytes)) u_chk (.*);

// ===== test/first_fit_block_allocator_tb.sv =====
// Testbench for first_fit_block_allocator: a queue-fed driver, a monitor and
// a block-table model that predicts offset, status and byte counts.
// Depends on ffba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module first_fit_block_allocator_tb;
  import ffba_pkg::*;

  localparam int unsigned Arena    = 4194304;
  localparam int unsigned Hdr      = 24;
  localparam int unsigned MinSplit = 16;
  localparam int unsigned MaxBlk   = 64;
  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;
  localparam int unsigned CycleLimit = 3000000;

  typedef struct packed {
    logic              mode;
    logic [BytesW-1:0] req_bytes;
    logic [OffW-1:0]   foff;
  } request_t;

  typedef struct packed {
    logic [OffW-1:0]   offset;
    status_e           status;
    logic [BytesW-1:0] used;
    logic [BytesW-1:0] avail;
  } grant_t;

  logic clk, rst_n;
  logic push, full, empty, pop;
  logic mode;
  logic [BytesW-1:0] req_bytes;
  logic [OffW-1:0] free_off;
  logic [OffW-1:0] payload_offset;
  logic [StatW-1:0] status;
  logic [BytesW-1:0] bytes_used, bytes_free;

  first_fit_block_allocator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .push(push), .full(full),
    .mode_i(mode), .request_bytes_i(req_bytes), .free_offset_i(free_off),
    .empty(empty), .pop(pop),
    .payload_offset_o(payload_offset), .status_o(status),
    .bytes_used_o(bytes_used), .bytes_free_o(bytes_free)
  );

  request_t pending_reqs[$];
  grant_t   expected_grants[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit busy_side_idle = 1'b1;   // cleared during the no-idle stretch

  // Arena table model
  int unsigned blk_start[MaxBlk];
  int unsigned blk_size[MaxBlk];
  bit          blk_free[MaxBlk];
  int unsigned blk_count;
  int unsigned used_bytes;

  task automatic table_reset();
    for (int i = 0; i < MaxBlk; i++) begin
      blk_start[i] = 0; blk_size[i] = 0; blk_free[i] = 0;
    end
    blk_size[0] = Arena - Hdr;
    blk_free[0] = 1;
    blk_count = 1;
    used_bytes = 0;
  endtask

  function automatic void merge_free_neighbors();
    int unsigned i;
    i = 0;
    while (i + 1 < blk_count) begin
      if (blk_free[i] && blk_free[i+1]) begin
        blk_size[i] += blk_size[i+1] + Hdr;
        for (int unsigned j = i + 1; j + 1 < blk_count; j++) begin
          blk_start[j] = blk_start[j+1];
          blk_size[j]  = blk_size[j+1];
          blk_free[j]  = blk_free[j+1];
        end
        blk_count--;
        blk_start[blk_count] = 0; blk_size[blk_count] = 0; blk_free[blk_count] = 0;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic grant_t allocate_or_release(request_t r);
    grant_t g;
    int unsigned hit;
    longint unsigned need, sz;
    g.offset = '0;
    g.status = StDone;
    if (r.mode == ModeAlloc) begin
      if (r.req_bytes == 0) begin
        g.status = StZeroSize;
      end else begin
        need = (longint'(r.req_bytes) + 15) & ~64'd15;
        hit = blk_count;
        for (int unsigned i = 0; i < blk_count; i++)
          if (blk_free[i] && blk_size[i] >= need) begin hit = i; break; end
        if (hit == blk_count) begin
          g.status = StNoFit;
        end else begin
          sz = blk_size[hit];
          if (sz >= need + Hdr + MinSplit && blk_count < MaxBlk) begin
            for (int unsigned j = blk_count; j > hit + 1; j--) begin
              blk_start[j] = blk_start[j-1];
              blk_size[j]  = blk_size[j-1];
              blk_free[j]  = blk_free[j-1];
            end
            blk_start[hit+1] = blk_start[hit] + Hdr + int'(need);
            blk_size[hit+1]  = int'(sz - need - Hdr);
            blk_free[hit+1]  = 1;
            blk_size[hit]    = int'(need);
            blk_count++;
          end
          blk_free[hit] = 0;
          used_bytes += blk_size[hit] + Hdr;
          g.offset = OffW'(blk_start[hit] + Hdr);
        end
      end
    end else begin
      if (r.foff == 0) begin
        g.status = StNullFree;
      end else begin
        hit = blk_count;
        for (int unsigned i = 0; i < blk_count; i++)
          if (!blk_free[i] && blk_start[i] + Hdr == r.foff) begin hit = i; break; end
        if (hit == blk_count) begin
          g.status = StBadFree;
        end else begin
          blk_free[hit] = 1;
          used_bytes = (used_bytes >= blk_size[hit] + Hdr) ?
                       used_bytes - (blk_size[hit] + Hdr) : 0;
          merge_free_neighbors();
        end
      end
    end
    g.used  = BytesW'(used_bytes);
    g.avail = BytesW'(Arena - used_bytes);
    return g;
  endfunction

  // Stimulus helpers
  function automatic request_t alloc_req(int unsigned nbytes);
    request_t r;
    r.mode = ModeAlloc; r.req_bytes = BytesW'(nbytes); r.foff = OffW'($urandom);
    return r;
  endfunction

  function automatic request_t free_req(int unsigned off);
    request_t r;
    r.mode = ModeFree; r.req_bytes = BytesW'($urandom); r.foff = OffW'(off);
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("mismatch %s: got 0x%0h expected 0x%0h at cycle %0d",
             what, got, want, cycle_count);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver: present the head of the pending queue at the falling edge
  logic accepted_prev;
  always @(posedge clk) accepted_prev <= push && !full && rst_n;

  always @(negedge clk) begin
    request_t r;
    if (accepted_prev) void'(pending_reqs.pop_front());
    if (rst_n && pending_reqs.size() > 0 &&
        !(busy_side_idle && $urandom_range(99) < 37)) begin
      r = pending_reqs[0];
      push      <= 1'b1;
      mode      <= r.mode;
      req_bytes <= r.req_bytes;
      free_off  <= r.foff;
    end else begin
      push <= 1'b0;
    end
    pop <= rst_n && !(busy_side_idle && $urandom_range(99) < 37);
  end

  // Prediction happens at acceptance so the model order matches the block
  always @(posedge clk) begin
    if (rst_n && push && !full) expected_grants.push_back(allocate_or_release(pending_reqs[0]));
  end

  // Monitor
  always @(posedge clk) begin
    grant_t want;
    if (rst_n) cycle_count++;
    if (rst_n && pop && !empty) begin
      if (expected_grants.size() == 0) begin
        report_mismatch("unexpected result", payload_offset, 0);
      end else begin
        want = expected_grants.pop_front();
        if (payload_offset !== want.offset) report_mismatch("payload_offset", payload_offset, want.offset);
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (bytes_used !== want.used) report_mismatch("bytes_used", bytes_used, want.used);
        if (bytes_free !== want.avail) report_mismatch("bytes_free", bytes_free, want.avail);
      end
    end
  end

  task automatic add_random_items(int unsigned n);
    int unsigned pick, k;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        // mostly small sizes, a few huge ones
        k = ($urandom_range(19) == 0) ? $urandom_range(Arena) : $urandom_range(2000);
        if ($urandom_range(49) == 0) k = $urandom;   // random value across all request bits
        pending_reqs.push_back(alloc_req(k));
      end else if (pick < 85) begin
        // candidate payload offsets: header plus multiples of 16 and of header plus 16
        pending_reqs.push_back(free_req(Hdr + 16 * $urandom_range(40) +
                                        (Hdr + 16) * $urandom_range(40)));
      end else if (pick < 92) begin
        pending_reqs.push_back(free_req($urandom));
      end else if (pick < 96) begin
        pending_reqs.push_back(free_req(0));
      end else begin
        pending_reqs.push_back(alloc_req(0));
      end
    end
  endtask

  initial begin
    push = 1'b0; pop = 1'b0; mode = ModeAlloc; req_bytes = '0; free_off = '0;
    rst_n = 1'b0;
    table_reset();
    // Directed: extremes, zero size, null free, bad free, no fit, split, merge
    pending_reqs.push_back(alloc_req(0));
    pending_reqs.push_back(free_req(0));
    pending_reqs.push_back(free_req(Hdr));                // not allocated yet
    pending_reqs.push_back(alloc_req(Arena));             // no fit
    pending_reqs.push_back(alloc_req(8388607));           // all request bits
    pending_reqs.push_back(alloc_req(1));
    pending_reqs.push_back(alloc_req(16));
    pending_reqs.push_back(alloc_req(17));
    pending_reqs.push_back(free_req(Hdr + 16 + Hdr));     // middle block
    pending_reqs.push_back(free_req(Hdr + 16 + Hdr));     // double free
    pending_reqs.push_back(free_req(Hdr));                // merges with middle
    pending_reqs.push_back(free_req(4194303));            // all offset bits
    pending_reqs.push_back(free_req(Hdr + 2 * (16 + Hdr)));
    pending_reqs.push_back(alloc_req(Arena - Hdr));       // whole free arena, no fit after rounding
    pending_reqs.push_back(alloc_req(1));                 // fits, since the arena is still free
    pending_reqs.push_back(free_req(Hdr));
    for (int i = 0; i < 70; i++) pending_reqs.push_back(alloc_req(1));  // table fills
    for (int i = 0; i < 70; i++) pending_reqs.push_back(free_req(Hdr + i * (16 + Hdr)));
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    add_random_items(350);
    wait (pending_reqs.size() == 0);
    busy_side_idle = 1'b0;
    add_random_items(250);
    wait (pending_reqs.size() == 0);
    busy_side_idle = 1'b1;
    add_random_items(250);
    wait (pending_reqs.size() == 0 && expected_grants.size() == 0);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
